@@ hdl/cmwb_pkg.sv @@
// shared types and constants for the card-marking write barrier
// no dependencies; used by every module under hdl
`default_nettype none

package cmwb_pkg;

  localparam int unsigned BASE_W     = 48;
  localparam int unsigned LEN_W      = 49;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned MADDR_W    = 48;
  localparam int unsigned VIEW_W     = 32;
  localparam int unsigned CFG_DATA_W = 49;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_CNT    = 5;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YOUNG_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YOUNG_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_TAG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRING_TAG   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIGINT_TAG   = 3'd7;

  // verdict codes
  localparam logic [2:0] VERDICT_NULL_HOLDER = 3'd0;
  localparam logic [2:0] VERDICT_NOT_PTR     = 3'd1;
  localparam logic [2:0] VERDICT_NOT_OLD     = 3'd2;
  localparam logic [2:0] VERDICT_NOT_YOUNG   = 3'd3;
  localparam logic [2:0] VERDICT_MARKED      = 3'd4;

  // counter slots
  localparam int unsigned CNT_CALLS     = 0;
  localparam int unsigned CNT_NON_PTR   = 1;
  localparam int unsigned CNT_NON_OLD   = 2;
  localparam int unsigned CNT_NON_YOUNG = 3;
  localparam int unsigned CNT_MARKED    = 4;

  typedef struct packed {
    logic [63:0] holder_word;
    logic [63:0] stored_word;
  } in_word_t;

  typedef struct packed {
    logic [VIEW_W-1:0] calls_seen;
    logic [VIEW_W-1:0] non_pointer_seen;
    logic [VIEW_W-1:0] non_old_seen;
    logic [VIEW_W-1:0] non_young_seen;
    logic [VIEW_W-1:0] marked_seen;
  } counts_t;

  typedef struct packed {
    logic               mark;
    logic [MADDR_W-1:0] mark_address;
    logic [2:0]         verdict;
    logic [VIEW_W-1:0]  calls_seen;
    logic [VIEW_W-1:0]  non_pointer_seen;
    logic [VIEW_W-1:0]  non_old_seen;
    logic [VIEW_W-1:0]  non_young_seen;
    logic [VIEW_W-1:0]  marked_seen;
  } out_word_t;

  typedef struct packed {
    logic              table_active;
    logic [BASE_W-1:0] old_base;
    logic [LEN_W-1:0]  old_length;
    logic [BASE_W-1:0] young_base;
    logic [LEN_W-1:0]  young_length;
    logic [TAG_W-1:0]  object_tag;
    logic [TAG_W-1:0]  string_tag;
    logic [TAG_W-1:0]  bigint_tag;
  } cfg_t;

  // counter update request from the classifier stage
  typedef struct packed {
    logic       fire;
    logic [2:0] verdict;
  } cnt_evt_t;

endpackage

`default_nettype wire

@@ hdl/cmwb_classify.sv @@
// store classifier: pointer decode, old and young range tests, verdict
// purely combinational; uses cmwb_pkg types and verdict codes
`default_nettype none

module cmwb_classify #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  cmwb_pkg::in_word_t          item_i,
  input  cmwb_pkg::cfg_t              cfg_i,
  output logic [2:0]                  verdict_o,
  output logic [cmwb_pkg::MADDR_W-1:0] mark_address_o
);

  localparam int unsigned TAG_BITS = 64 - ADDR_BITS;
  localparam int unsigned TW = (TAG_BITS > cmwb_pkg::TAG_W) ? TAG_BITS : cmwb_pkg::TAG_W;
  localparam int unsigned RW =
      ((ADDR_BITS > cmwb_pkg::LEN_W) ? ADDR_BITS : cmwb_pkg::LEN_W) + 1;

  logic [ADDR_BITS-1:0] holder;
  logic [ADDR_BITS-1:0] payload;
  logic [TW-1:0]        tag;
  logic                 tag_match;
  logic                 is_ptr;
  logic [RW-1:0]        h_ext, ob_ext, ol_ext, h_diff;
  logic [RW-1:0]        p_ext, yb_ext, yl_ext, p_diff;
  logic                 holder_old;
  logic                 ptr_young;
  logic [63:0]          holder_wide;

  always_comb begin
    holder  = item_i.holder_word[ADDR_BITS-1:0];
    payload = item_i.stored_word[ADDR_BITS-1:0];
    tag     = TW'(item_i.stored_word[63:ADDR_BITS]);

    tag_match = (tag == TW'(cfg_i.object_tag)) || (tag == TW'(cfg_i.string_tag)) ||
                (tag == TW'(cfg_i.bigint_tag));
    // untagged word or configured tag, and the address part must be nonzero
    is_ptr = (payload != '0) && ((tag == '0) || tag_match);

    h_ext  = RW'(holder);
    ob_ext = RW'(cfg_i.old_base);
    ol_ext = RW'(cfg_i.old_length);
    h_diff = h_ext - ob_ext;
    holder_old = (ol_ext != '0) && (h_ext >= ob_ext) && (h_diff < ol_ext);

    p_ext  = RW'(payload);
    yb_ext = RW'(cfg_i.young_base);
    yl_ext = RW'(cfg_i.young_length);
    p_diff = p_ext - yb_ext;
    ptr_young = (yl_ext != '0) && (p_ext >= yb_ext) && (p_diff < yl_ext);

    holder_wide    = 64'(holder);
    mark_address_o = '0;

    if (holder == '0) begin
      verdict_o = cmwb_pkg::VERDICT_NULL_HOLDER;
    end else if (!is_ptr) begin
      verdict_o = cmwb_pkg::VERDICT_NOT_PTR;
    end else if (!cfg_i.table_active || !holder_old) begin
      verdict_o = cmwb_pkg::VERDICT_NOT_OLD;
    end else if (!ptr_young) begin
      verdict_o = cmwb_pkg::VERDICT_NOT_YOUNG;
    end else begin
      verdict_o      = cmwb_pkg::VERDICT_MARKED;
      mark_address_o = holder_wide[cmwb_pkg::MADDR_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/cmwb_counters.sv @@
// five wrapping statistics counters, bumped by verdict
// presents the post-update values as 32-bit views; uses cmwb_pkg
`default_nettype none

module cmwb_counters #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmwb_pkg::cnt_evt_t  evt_i,
  output cmwb_pkg::counts_t   next_o
);

  localparam int unsigned VW =
      (COUNT_BITS > cmwb_pkg::VIEW_W) ? COUNT_BITS : cmwb_pkg::VIEW_W;

  logic [COUNT_BITS-1:0]    cnt_q [cmwb_pkg::NUM_CNT];
  logic [COUNT_BITS-1:0]    cnt_d [cmwb_pkg::NUM_CNT];
  logic [cmwb_pkg::NUM_CNT-1:0] hit;
  logic [VW-1:0]            view [cmwb_pkg::NUM_CNT];

  always_comb begin
    hit = '0;
    hit[cmwb_pkg::CNT_CALLS]     = 1'b1;
    hit[cmwb_pkg::CNT_NON_PTR]   = (evt_i.verdict == cmwb_pkg::VERDICT_NOT_PTR);
    hit[cmwb_pkg::CNT_NON_OLD]   = (evt_i.verdict == cmwb_pkg::VERDICT_NOT_OLD);
    hit[cmwb_pkg::CNT_NON_YOUNG] = (evt_i.verdict == cmwb_pkg::VERDICT_NOT_YOUNG);
    hit[cmwb_pkg::CNT_MARKED]    = (evt_i.verdict == cmwb_pkg::VERDICT_MARKED);
    for (int i = 0; i < cmwb_pkg::NUM_CNT; i++) begin
      cnt_d[i] = (evt_i.fire && hit[i]) ? cnt_q[i] + COUNT_BITS'(1) : cnt_q[i];
      view[i]  = VW'(cnt_d[i]);
    end
    next_o.calls_seen       = view[cmwb_pkg::CNT_CALLS][cmwb_pkg::VIEW_W-1:0];
    next_o.non_pointer_seen = view[cmwb_pkg::CNT_NON_PTR][cmwb_pkg::VIEW_W-1:0];
    next_o.non_old_seen     = view[cmwb_pkg::CNT_NON_OLD][cmwb_pkg::VIEW_W-1:0];
    next_o.non_young_seen   = view[cmwb_pkg::CNT_NON_YOUNG][cmwb_pkg::VIEW_W-1:0];
    next_o.marked_seen      = view[cmwb_pkg::CNT_MARKED][cmwb_pkg::VIEW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cmwb_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < cmwb_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/card_marking_write_barrier.sv @@
// a store word passes the input register, the classifier and the output register
// throughput: one store word per cycle while the output is not stalled
// in_stall_o rises only when both stages are full and the output is stalled
// reset clears the config registers, the counters and both stage valids
// depends on cmwb_pkg, cmwb_classify and cmwb_counters
`default_nettype none

module card_marking_write_barrier #(
  parameter int unsigned ADDR_BITS  = 48,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cmwb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cmwb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cmwb_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cmwb_pkg::out_word_t               out_data_o
);

  cmwb_pkg::cfg_t      cfg_q;
  cmwb_pkg::in_word_t  in_q;
  logic                in_valid_q;
  cmwb_pkg::out_word_t out_q;
  logic                out_valid_q;

  logic                          out_load;
  logic                          in_load;
  logic [2:0]                    verdict;
  logic [cmwb_pkg::MADDR_W-1:0]  mark_address;
  cmwb_pkg::cnt_evt_t            cnt_evt;
  cmwb_pkg::counts_t             counts;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_load    = !in_valid_q || out_load;
  assign in_stall_o = !in_load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cmwb_pkg::REG_TABLE_ACTIVE: cfg_q.table_active <= cfg_data_i[0];
        cmwb_pkg::REG_OLD_BASE:     cfg_q.old_base     <= cfg_data_i[cmwb_pkg::BASE_W-1:0];
        cmwb_pkg::REG_OLD_LENGTH:   cfg_q.old_length   <= cfg_data_i[cmwb_pkg::LEN_W-1:0];
        cmwb_pkg::REG_YOUNG_BASE:   cfg_q.young_base   <= cfg_data_i[cmwb_pkg::BASE_W-1:0];
        cmwb_pkg::REG_YOUNG_LENGTH: cfg_q.young_length <= cfg_data_i[cmwb_pkg::LEN_W-1:0];
        cmwb_pkg::REG_OBJECT_TAG:   cfg_q.object_tag   <= cfg_data_i[cmwb_pkg::TAG_W-1:0];
        cmwb_pkg::REG_STRING_TAG:   cfg_q.string_tag   <= cfg_data_i[cmwb_pkg::TAG_W-1:0];
        cmwb_pkg::REG_BIGINT_TAG:   cfg_q.bigint_tag   <= cfg_data_i[cmwb_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  cmwb_classify #(
    .ADDR_BITS(ADDR_BITS)
  ) u_classify (
    .item_i        (in_q),
    .cfg_i         (cfg_q),
    .verdict_o     (verdict),
    .mark_address_o(mark_address)
  );

  // counters advance only when the word moves into the output register
  assign cnt_evt.fire    = in_valid_q && out_load;
  assign cnt_evt.verdict = verdict;

  cmwb_counters #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counters (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (cnt_evt),
    .next_o(counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (cnt_evt.fire) begin
      out_q.mark             <= (verdict == cmwb_pkg::VERDICT_MARKED);
      out_q.mark_address     <= mark_address;
      out_q.verdict          <= verdict;
      out_q.calls_seen       <= counts.calls_seen;
      out_q.non_pointer_seen <= counts.non_pointer_seen;
      out_q.non_old_seen     <= counts.non_old_seen;
      out_q.non_young_seen   <= counts.non_young_seen;
      out_q.marked_seen      <= counts.marked_seen;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench for card_marking_write_barrier: queued store words under random pacing,
// each result word checked against a predicted barrier verdict and counter values
// depends on cmwb_pkg and the rtl under hdl

module tb;
  import cmwb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_data_o;

  card_marking_write_barrier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the config registers and the statistics counters
  cfg_t        shadow_cfg = '0;
  logic [31:0] calls_cnt = '0;
  logic [31:0] non_ptr_cnt = '0;
  logic [31:0] non_old_cnt = '0;
  logic [31:0] non_young_cnt = '0;
  logic [31:0] marked_cnt = '0;

  in_word_t  store_q[$];
  out_word_t verdict_q[$];
  out_word_t oldest_verdict;

  logic in_fire = 1'b0;
  logic recv_hold = 1'b0;
  logic hold_req = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   errors = 0;
  int   cycles = 0;

  function automatic bit in_space(logic [63:0] addr, logic [47:0] base, logic [48:0] len);
    if (len == 0) return 1'b0;
    if (addr < {16'h0, base}) return 1'b0;
    return (addr - {16'h0, base}) < {15'h0, len};
  endfunction

  function automatic out_word_t predict_barrier(in_word_t w);
    out_word_t   r;
    logic [47:0] holder;
    logic [63:0] val;
    logic [15:0] tg;
    logic [63:0] ptr;
    bit          is_ptr;
    holder = w.holder_word[47:0];
    val    = w.stored_word;
    tg     = val[63:48];
    r      = '0;
    ptr    = '0;
    is_ptr = 1'b0;
    calls_cnt++;
    if (holder == 0) begin
      r.verdict = VERDICT_NULL_HOLDER;
    end else begin
      // zero tag wins over the configured tags, so a zero tag register never matches
      if (val == 0) begin
        is_ptr = 1'b0;
      end else if (tg == 0) begin
        ptr    = val;
        is_ptr = 1'b1;
      end else if (tg == shadow_cfg.object_tag || tg == shadow_cfg.string_tag ||
                   tg == shadow_cfg.bigint_tag) begin
        ptr    = {16'h0, val[47:0]};
        is_ptr = (ptr != 0);
      end
      if (!is_ptr) begin
        non_ptr_cnt++;
        r.verdict = VERDICT_NOT_PTR;
      end else if (!shadow_cfg.table_active ||
                   !in_space({16'h0, holder}, shadow_cfg.old_base, shadow_cfg.old_length)) begin
        non_old_cnt++;
        r.verdict = VERDICT_NOT_OLD;
      end else if (!in_space(ptr, shadow_cfg.young_base, shadow_cfg.young_length)) begin
        non_young_cnt++;
        r.verdict = VERDICT_NOT_YOUNG;
      end else begin
        marked_cnt++;
        r.verdict      = VERDICT_MARKED;
        r.mark         = 1'b1;
        r.mark_address = holder;
      end
    end
    r.calls_seen       = calls_cnt;
    r.non_pointer_seen = non_ptr_cnt;
    r.non_old_seen     = non_old_cnt;
    r.non_young_seen   = non_young_cnt;
    r.marked_seen      = marked_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // output check, then record the word taken on the input this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: %h", out_data_o));
        end else begin
          oldest_verdict = verdict_q.pop_front();
          check_field("mark", out_data_o.mark, oldest_verdict.mark);
          check_field("mark_address", out_data_o.mark_address, oldest_verdict.mark_address);
          check_field("verdict", out_data_o.verdict, oldest_verdict.verdict);
          check_field("calls_seen", out_data_o.calls_seen, oldest_verdict.calls_seen);
          check_field("non_pointer_seen", out_data_o.non_pointer_seen,
                      oldest_verdict.non_pointer_seen);
          check_field("non_old_seen", out_data_o.non_old_seen, oldest_verdict.non_old_seen);
          check_field("non_young_seen", out_data_o.non_young_seen,
                      oldest_verdict.non_young_seen);
          check_field("marked_seen", out_data_o.marked_seen, oldest_verdict.marked_seen);
        end
      end
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) verdict_q.push_back(predict_barrier(in_data_i));
    end
  end

  // sender: a new word only once the current one is gone
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (store_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_data_i  <= store_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : recv_hold_off
    wait (hold_req);
    @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    case (idx)
      REG_TABLE_ACTIVE: shadow_cfg.table_active = data[0];
      REG_OLD_BASE:     shadow_cfg.old_base     = data[47:0];
      REG_OLD_LENGTH:   shadow_cfg.old_length   = data;
      REG_YOUNG_BASE:   shadow_cfg.young_base   = data[47:0];
      REG_YOUNG_LENGTH: shadow_cfg.young_length = data;
      REG_OBJECT_TAG:   shadow_cfg.object_tag   = data[15:0];
      REG_STRING_TAG:   shadow_cfg.string_tag   = data[15:0];
      REG_BIGINT_TAG:   shadow_cfg.bigint_tag   = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // writes every register, with junk above each register's width
  task automatic program_config(cfg_t c);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_TABLE_ACTIVE, {junk[48:1], c.table_active});
    write_reg(REG_OLD_BASE, {junk[2], c.old_base});
    write_reg(REG_OLD_LENGTH, c.old_length);
    write_reg(REG_YOUNG_BASE, {junk[3], c.young_base});
    write_reg(REG_YOUNG_LENGTH, c.young_length);
    write_reg(REG_OBJECT_TAG, {junk[52:20], c.object_tag});
    write_reg(REG_STRING_TAG, {junk[57:25], c.string_tag});
    write_reg(REG_BIGINT_TAG, {junk[62:30], c.bigint_tag});
  endtask

  function automatic logic [48:0] rand_len();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return 49'd0;
      1: return 49'($urandom_range(4096, 1));
      2: return {1'b0, r[47:0]};
      3: return {9'h0, r[39:0]};
      default: return 49'h1_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_tag();
    if ($urandom_range(4) == 0) return 16'h0;
    return 16'($urandom);
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.table_active = ($urandom_range(99) < 85);
    c.old_base     = {16'($urandom), 32'($urandom)};
    c.old_length   = rand_len();
    c.young_base   = {16'($urandom), 32'($urandom)};
    c.young_length = rand_len();
    c.object_tag   = rand_tag();
    c.string_tag   = rand_tag();
    c.bigint_tag   = ($urandom_range(3) == 0) ? c.object_tag : rand_tag();
    return c;
  endfunction

  // addresses around the edges of a space, inside it, or anywhere
  function automatic logic [47:0] pick_addr(logic [47:0] base, logic [48:0] len);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return base;
      1: return base + len[47:0] - 48'd1;
      2: return base + len[47:0];
      3: return base - 48'd1;
      4: return (len == 0) ? r[47:0] : 48'(base + (r % len));
      default: return r[47:0];
    endcase
  endfunction

  function automatic in_word_t make_store();
    in_word_t    w;
    logic [47:0] p;
    int          k;
    w.holder_word = {$urandom, $urandom};
    k = $urandom_range(99);
    if (k < 5) w.holder_word[47:0] = '0;
    else if (k < 70) w.holder_word[47:0] = pick_addr(shadow_cfg.old_base, shadow_cfg.old_length);
    p = pick_addr(shadow_cfg.young_base, shadow_cfg.young_length);
    k = $urandom_range(99);
    if (k < 30) w.stored_word = {16'h0, p};
    else if (k < 40) w.stored_word = {shadow_cfg.object_tag, p};
    else if (k < 50) w.stored_word = {shadow_cfg.string_tag, p};
    else if (k < 60) w.stored_word = {shadow_cfg.bigint_tag, p};
    else if (k < 65) w.stored_word = {shadow_cfg.object_tag, 48'h0};
    else if (k < 70) w.stored_word = '0;
    else if (k < 78) w.stored_word = {16'($urandom), p};
    else w.stored_word = {$urandom, $urandom};
    return w;
  endfunction

  task automatic push_store(logic [63:0] holder, logic [63:0] stored);
    in_word_t w;
    w.holder_word = holder;
    w.stored_word = stored;
    store_q.push_back(w);
  endtask

  // sampled just after the edge, clear of both driving edges
  task automatic wait_drained();
    while (store_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  task automatic set_pace(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  initial begin : stimulus
    cfg_t        c;
    logic [47:0] ob, yb;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config: no table, all tags zero
    set_pace(0);
    push_store(64'hFFFF_0000_0000_0000, 64'h0000_0000_0000_1000);
    push_store(64'h0000_0000_0000_1000, 64'h0000_0000_0000_2000);
    push_store(64'h0000_0000_0000_1000, 64'h0);
    push_store(64'h0000_0000_0000_1000, 64'h0001_0000_0000_2000);
    wait_drained();

    c.table_active = 1'b1;
    c.old_base     = 48'h1000_0000_0000;
    c.old_length   = 49'h0_1000_0000_0000;
    c.young_base   = 48'h2000_0000_0000;
    c.young_length = 49'h0_0800_0000_0000;
    c.object_tag   = 16'hFFF9;
    c.string_tag   = 16'hFFFA;
    c.bigint_tag   = 16'hFFFB;
    program_config(c);
    ob = c.old_base;
    yb = c.young_base;
    push_store(64'hFFFF_0000_0000_0000, {16'h0, yb});
    push_store({16'h0, ob}, 64'h0);
    push_store({16'h0, ob}, {16'h0, yb});
    push_store(64'h0000_1FFF_FFFF_FFFF, 64'h0000_27FF_FFFF_FFFF);
    push_store(64'h0000_2000_0000_0000, {16'h0, yb});
    push_store({16'h0, ob - 48'd1}, {16'h0, yb});
    push_store({16'h0, ob}, {16'h0, yb - 48'd1});
    push_store({16'h0, ob}, 64'h0000_2800_0000_0000);
    push_store({16'h0, ob}, {16'hFFF9, yb});
    push_store({16'h0, ob + 48'd8}, {16'hFFFA, yb + 48'd5});
    push_store({16'h0, ob + 48'd16}, {16'hFFFB, 48'h27FF_FFFF_FFFF});
    push_store({16'h0, ob}, {16'hFFF9, 48'h0});
    push_store({16'h0, ob}, {16'h1234, yb});
    push_store({16'h0, ob}, 64'hFFFF_FFFF_FFFF_FFFF);
    push_store(64'hFFFF_FFFF_FFFF_FFFF, {16'h0, yb});
    push_store({16'hFFF9, ob + 48'd8}, {16'h0, yb});
    push_store({16'h0, ob}, 64'h1);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          // every address is old and young
          c.table_active = 1'b1;
          c.old_base     = '0;
          c.old_length   = 49'h1_0000_0000_0000;
          c.young_base   = '0;
          c.young_length = 49'h1_0000_0000_0000;
          c.object_tag   = 16'hFFFF;
          c.string_tag   = 16'h0001;
          c.bigint_tag   = 16'h8000;
        end
        1: begin
          // one-byte spaces at the top address, zero tags
          c.table_active = 1'b1;
          c.old_base     = '1;
          c.old_length   = 49'd1;
          c.young_base   = '1;
          c.young_length = 49'd1;
          c.object_tag   = '0;
          c.string_tag   = '0;
          c.bigint_tag   = '0;
        end
        2: begin
          c = random_config();
          c.old_length   = '0;
          c.young_length = '0;
        end
        3: begin
          c = random_config();
          c.table_active = 1'b0;
        end
        default: c = random_config();
      endcase
      program_config(c);
      set_pace(ph);
      for (int i = 0; i < PHASE_WORDS; i++) store_q.push_back(make_store());
      wait_drained();
    end

    // receiver holds off while the sender keeps offering
    c = random_config();
    c.table_active = 1'b1;
    program_config(c);
    set_pace(0);
    for (int i = 0; i < 120; i++) store_q.push_back(make_store());
    hold_req = 1'b1;
    wait_drained();

    repeat (4) @(posedge clk_i);
    if (verdict_q.size() != 0) report_mismatch("expected results never arrived");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ card_marking_write_barrier.f @@
hdl/cmwb_pkg.sv
hdl/cmwb_classify.sv
hdl/cmwb_counters.sv
hdl/card_marking_write_barrier.sv
tb/tb.sv
